[src/ipsvpwm_pkg.sv]
package ipsvpwm_pkg;

   localparam int ANGLE_BITS       = 16;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int DUTY_BITS        = 16;

   localparam int ROM_ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int FIELD_BITS    = 16;

   // sqrt(3) in Q16
   localparam logic signed [51:0] SQRT3_Q16 = 52'sd113512;
   localparam logic signed [40:0] ONE_Q30   = 41'sd1 <<< 30;

   localparam logic [63:0] TAY_C1 = 64'd1686629713;
   localparam logic [63:0] TAY_C3 = 64'd693598668;
   localparam logic [63:0] TAY_C5 = 64'd85569306;
   localparam logic [63:0] TAY_C7 = 64'd5026995;
   localparam logic [63:0] TAY_C9 = 64'd172272;

   typedef logic [14:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   typedef logic signed [FIELD_BITS-1:0] field_type;
   typedef logic [FIELD_BITS-1:0]        duty_type;

   // order of phases from highest to lowest duty
   typedef enum logic [2:0] {
      SECT_ABC,
      SECT_BCA,
      SECT_BAC,
      SECT_CBA,
      SECT_CAB,
      SECT_ACB
   } sector_type;

   // quarter-wave sine in Q15, Taylor series to x^9 with Q30 coefficients
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  e;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x  = (64'(k) << 30) / 64'(SINE_TABLE_DEPTH);
         x2 = (x * x) >> 30;
         t  = TAY_C9;
         t  = TAY_C7 - ((x2 * t) >> 30);
         t  = TAY_C5 - ((x2 * t) >> 30);
         t  = TAY_C3 - ((x2 * t) >> 30);
         t  = TAY_C1 - ((x2 * t) >> 30);
         s  = (x * t) >> 30;
         e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         if (e > 64'd32767) begin
            e = 64'd32767;
         end
         rom[k] = e[14:0];
      end
      return rom;
   endfunction

endpackage

[src/ipsvpwm_if.sv]
interface ipsvpwm_req_if;
   import ipsvpwm_pkg::*;
   logic      valid;
   logic      ready;
   field_type d_voltage;
   field_type q_voltage;
   duty_type  elec_angle;

   modport source (output valid, d_voltage, q_voltage, elec_angle, input ready);
   modport sink   (input valid, d_voltage, q_voltage, elec_angle, output ready);
endinterface

interface ipsvpwm_rsp_if;
   import ipsvpwm_pkg::*;
   logic     valid;
   logic     ready;
   duty_type duty_a;
   duty_type duty_b;
   duty_type duty_c;

   modport source (output valid, duty_a, duty_b, duty_c, input ready);
   modport sink   (input valid, duty_a, duty_b, duty_c, output ready);
endinterface

[src/ipsvpwm_sincos.sv]
module ipsvpwm_sincos (
   input  logic                               clock,
   input  logic                               en,
   input  logic [ipsvpwm_pkg::ANGLE_BITS-1:0] angle,
   output logic [14:0]                        sin_mag_ff,
   output logic [14:0]                        cos_mag_ff,
   output logic                               sin_neg_ff,
   output logic                               cos_neg_ff
);
   import ipsvpwm_pkg::*;

   localparam sine_rom_type ROM = build_sine_rom();

   logic [1:0]               quad_s;
   logic [1:0]               quad_c;
   logic [ANGLE_BITS-3:0]    frac;
   logic [ROM_ADDR_BITS-1:0] idx;
   logic [ROM_ADDR_BITS-1:0] mirror;
   logic [ROM_ADDR_BITS-1:0] sin_addr;
   logic [ROM_ADDR_BITS-1:0] cos_addr;

   always_comb begin
      quad_s   = angle[ANGLE_BITS-1 -: 2];
      quad_c   = quad_s + 2'd1;
      frac     = angle[ANGLE_BITS-3:0];
      idx      = ROM_ADDR_BITS'((64'(frac) * 64'(SINE_TABLE_DEPTH)) >> (ANGLE_BITS - 2));
      mirror   = ROM_ADDR_BITS'(SINE_TABLE_DEPTH) - idx;
      sin_addr = quad_s[0] ? mirror : idx;
      cos_addr = quad_c[0] ? mirror : idx;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_mag_ff <= ROM[sin_addr];
         cos_mag_ff <= ROM[cos_addr];
         sin_neg_ff <= quad_s[1];
         cos_neg_ff <= quad_c[1];
      end
   end

endmodule

[src/ipsvpwm_rotate.sv]
module ipsvpwm_rotate (
   input  logic                    clock,
   input  logic                    en,
   input  logic [14:0]             sin_mag,
   input  logic [14:0]             cos_mag,
   input  logic                    sin_neg,
   input  logic                    cos_neg,
   input  ipsvpwm_pkg::field_type  d_volt,
   input  ipsvpwm_pkg::field_type  q_volt,
   output logic signed [51:0]      sa_prod_ff,
   output logic signed [32:0]      beta_out_ff
);
   import ipsvpwm_pkg::*;

   logic signed [15:0] sn;
   logic signed [15:0] cs;
   logic signed [31:0] p_cd_ff;
   logic signed [31:0] p_sq_ff;
   logic signed [31:0] p_sd_ff;
   logic signed [31:0] p_cq_ff;
   logic signed [32:0] alpha;
   logic signed [32:0] beta;

   always_comb begin
      sn = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      cs = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_cd_ff <= cs * d_volt;
         p_sq_ff <= sn * q_volt;
         p_sd_ff <= sn * d_volt;
         p_cq_ff <= cs * q_volt;
      end
   end

   always_comb begin
      alpha = 33'(p_cd_ff) - 33'(p_sq_ff);
      beta  = 33'(p_sd_ff) + 33'(p_cq_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_prod_ff  <= 52'(alpha) * SQRT3_Q16;
         beta_out_ff <= beta;
      end
   end

endmodule

[src/ipsvpwm_svm.sv]
module ipsvpwm_svm (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [51:0]      sa_prod,
   input  logic signed [32:0]      beta,
   output ipsvpwm_pkg::duty_type   duty_a_ff,
   output ipsvpwm_pkg::duty_type   duty_b_ff,
   output ipsvpwm_pkg::duty_type   duty_c_ff
);
   import ipsvpwm_pkg::*;

   logic signed [37:0] sa;
   logic signed [37:0] u;
   logic signed [37:0] v;
   logic signed [37:0] w;
   logic signed [37:0] t1_in;
   logic signed [37:0] t2_in;
   sector_type         sect_in;
   logic signed [37:0] t1_ff;
   logic signed [37:0] t2_ff;
   sector_type         sect_ff;
   logic signed [40:0] tmin;
   logic signed [40:0] tmid;
   logic signed [40:0] tmax;
   logic signed [40:0] da;
   logic signed [40:0] db;
   logic signed [40:0] dc;

   function automatic duty_type to_duty(input logic signed [40:0] t);
      logic signed [40:0] d;
      logic signed [40:0] full;
      full = (41'sd1 <<< DUTY_BITS) - 41'sd1;
      d    = t >>> (30 - DUTY_BITS);
      if (d < 0) begin
         d = '0;
      end else if (d > full) begin
         d = full;
      end
      return d[FIELD_BITS-1:0];
   endfunction

   always_comb begin
      sa = 38'(sa_prod >>> 16);
      u  = 38'(beta);
      v  = (sa - u) >>> 1;
      w  = (-(u + sa)) >>> 1;
      if (!u[37]) begin
         if (!v[37]) begin
            sect_in = SECT_ABC; t1_in = u;  t2_in = v;
         end else if (!w[37]) begin
            sect_in = SECT_BCA; t1_in = w;  t2_in = u;
         end else begin
            sect_in = SECT_BAC; t1_in = -w; t2_in = -v;
         end
      end else begin
         if (v[37]) begin
            sect_in = SECT_CBA; t1_in = -v; t2_in = -u;
         end else if (!w[37]) begin
            sect_in = SECT_CAB; t1_in = v;  t2_in = w;
         end else begin
            sect_in = SECT_ACB; t1_in = -u; t2_in = -w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         sect_ff <= sect_in;
      end
   end

   always_comb begin
      tmin = (ONE_Q30 - 41'(t1_ff) - 41'(t2_ff)) >>> 1;
      tmid = tmin + 41'(t1_ff);
      tmax = tmid + 41'(t2_ff);
      case (sect_ff)
         SECT_ABC: begin da = tmax; db = tmid; dc = tmin; end
         SECT_BCA: begin da = tmin; db = tmax; dc = tmid; end
         SECT_BAC: begin da = tmid; db = tmax; dc = tmin; end
         SECT_CBA: begin da = tmin; db = tmid; dc = tmax; end
         SECT_CAB: begin da = tmid; db = tmin; dc = tmax; end
         SECT_ACB: begin da = tmax; db = tmin; dc = tmid; end
         default:  begin da = tmin; db = tmin; dc = tmin; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         duty_a_ff <= to_duty(da);
         duty_b_ff <= to_duty(db);
         duty_c_ff <= to_duty(dc);
      end
   end

endmodule

[src/inverse_park_space_vector_pwm_core.sv]
// channel  | direction | payload
// req_bus  | in        | d_voltage, q_voltage, elec_angle
// rsp_bus  | out       | duty_a, duty_b, duty_c
//
// Five register stages: sine/cosine ROM read, four rotation products,
// alpha/beta sum with sqrt3 product, sector and vector times, duties.
// One beat in per cycle while the last stage is empty or being taken; each
// result is presented from the duties registers until rsp_bus takes it.
// Synchronous reset clears the stage valid bits only.
// A held result freezes all stages together; nothing is dropped or repeated.
module inverse_park_space_vector_pwm_core (
   input logic          clock,
   input logic          reset,
   ipsvpwm_req_if.sink   req_bus,
   ipsvpwm_rsp_if.source rsp_bus
);
   import ipsvpwm_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0]  valid_ff;
   logic               en;
   field_type          d_ff;
   field_type          q_ff;
   logic [14:0]        sin_mag;
   logic [14:0]        cos_mag;
   logic               sin_neg;
   logic               cos_neg;
   logic signed [51:0] sa_prod;
   logic signed [32:0] beta;

   // advance whenever the last stage is empty or being taken
   assign en            = !valid_ff[STAGES-1] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign rsp_bus.valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= req_bus.d_voltage;
         q_ff <= req_bus.q_voltage;
      end
   end

   ipsvpwm_sincos u_sincos (
      .clock      (clock),
      .en         (en),
      .angle      (ANGLE_BITS'(req_bus.elec_angle)),
      .sin_mag_ff (sin_mag),
      .cos_mag_ff (cos_mag),
      .sin_neg_ff (sin_neg),
      .cos_neg_ff (cos_neg)
   );

   ipsvpwm_rotate u_rotate (
      .clock       (clock),
      .en          (en),
      .sin_mag     (sin_mag),
      .cos_mag     (cos_mag),
      .sin_neg     (sin_neg),
      .cos_neg     (cos_neg),
      .d_volt      (d_ff),
      .q_volt      (q_ff),
      .sa_prod_ff  (sa_prod),
      .beta_out_ff (beta)
   );

   ipsvpwm_svm u_svm (
      .clock     (clock),
      .en        (en),
      .sa_prod   (sa_prod),
      .beta      (beta),
      .duty_a_ff (rsp_bus.duty_a),
      .duty_b_ff (rsp_bus.duty_b),
      .duty_c_ff (rsp_bus.duty_c)
   );

endmodule

[test/tb_inverse_park_space_vector_pwm_core.sv]
module tb_inverse_park_space_vector_pwm_core;
   import ipsvpwm_pkg::*;

   typedef struct packed {
      duty_type duty_a;
      duty_type duty_b;
      duty_type duty_c;
   } duties_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   int   cycles = 0;
   int   sent = 0;
   int   checked = 0;
   bit   no_idle = 1'b0;
   duties_type   pending_duties[$];
   sine_rom_type sine_q15_table;

   ipsvpwm_req_if req_bus ();
   ipsvpwm_rsp_if rsp_bus ();

   inverse_park_space_vector_pwm_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.d_voltage  = '0;
      req_bus.q_voltage  = '0;
      req_bus.elec_angle = '0;
      rsp_bus.ready      = 1'b0;
   end

   // floor division by a power of two on signed values
   function automatic longint floor_shr(longint x, int n);
      return x >>> n;
   endfunction

   function automatic longint sine_at(logic [15:0] angle);
      logic [1:0]  quad;
      logic [13:0] frac;
      int          idx;
      longint      mag;
      quad = angle[15:14];
      frac = angle[13:0];
      idx  = (int'(frac) * SINE_TABLE_DEPTH) >> 14;
      mag  = quad[0] ? longint'(sine_q15_table[SINE_TABLE_DEPTH - idx])
                     : longint'(sine_q15_table[idx]);
      return quad[1] ? -mag : mag;
   endfunction

   function automatic duty_type clamp_duty(longint t);
      longint d;
      d = floor_shr(t, 30 - DUTY_BITS);
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      return duty_type'(d);
   endfunction

   function automatic duties_type svpwm_duties(field_type dv, field_type qv,
                                               logic [15:0] angle);
      longint sn, cs, alpha, beta, sa, u, v, w, t1, t2, tmin, tmid, tmax;
      longint da, db, dc;
      duties_type r;
      sn    = sine_at(angle);
      cs    = sine_at(angle + 16'h4000);
      alpha = cs * longint'(dv) - sn * longint'(qv);
      beta  = sn * longint'(dv) + cs * longint'(qv);
      sa    = floor_shr(alpha * 113512, 16);
      u     = beta;
      v     = floor_shr(sa - beta, 1);
      w     = floor_shr(-(beta + sa), 1);
      if (u >= 0) begin
         if (v >= 0) begin t1 = u; t2 = v; end
         else if (w >= 0) begin t1 = w; t2 = u; end
         else begin t1 = -w; t2 = -v; end
      end else begin
         if (v < 0) begin t1 = -v; t2 = -u; end
         else if (w >= 0) begin t1 = v; t2 = w; end
         else begin t1 = -u; t2 = -w; end
      end
      tmin = floor_shr((longint'(1) << 30) - t1 - t2, 1);
      tmid = tmin + t1;
      tmax = tmid + t2;
      if (u >= 0) begin
         if (v >= 0) begin da = tmax; db = tmid; dc = tmin; end
         else if (w >= 0) begin da = tmin; db = tmax; dc = tmid; end
         else begin da = tmid; db = tmax; dc = tmin; end
      end else begin
         if (v < 0) begin da = tmin; db = tmid; dc = tmax; end
         else if (w >= 0) begin da = tmid; db = tmin; dc = tmax; end
         else begin da = tmax; db = tmin; dc = tmid; end
      end
      r.duty_a = clamp_duty(da);
      r.duty_b = clamp_duty(db);
      r.duty_c = clamp_duty(dc);
      return r;
   endfunction

   // valid stays high after the beat; the next idle cycle or the end drops it
   task automatic send_command(field_type dv, field_type qv, logic [15:0] angle);
      while (!no_idle && $urandom_range(99) < 37) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.d_voltage  <= dv;
      req_bus.q_voltage  <= qv;
      req_bus.elec_angle <= angle;
      pending_duties.push_back(svpwm_duties(dv, qv, angle));
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_duties.size() == 0) begin
               $error("duties beat with nothing pending");
               errors++;
            end else begin
               duties_type e;
               e = pending_duties.pop_front();
               if (rsp_bus.duty_a !== e.duty_a) begin
                  $error("duty_a expected %0d got %0d", e.duty_a, rsp_bus.duty_a);
                  errors++;
               end
               if (rsp_bus.duty_b !== e.duty_b) begin
                  $error("duty_b expected %0d got %0d", e.duty_b, rsp_bus.duty_b);
                  errors++;
               end
               if (rsp_bus.duty_c !== e.duty_c) begin
                  $error("duty_c expected %0d got %0d", e.duty_c, rsp_bus.duty_c);
                  errors++;
               end
               checked++;
            end
         end
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= 37);
      end
   end

   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("tb_inverse_park_space_vector_pwm_core: FAIL");
         $finish;
      end
   end

   task automatic test_extremes();
      field_type   vals[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
      logic [15:0] angles[4] = '{16'h0000, 16'hffff, 16'h4000, 16'hc000};
      foreach (vals[i]) send_command(vals[i], vals[(i + 2) % 5], angles[i % 4]);
      send_command(16'sh7fff, 16'sh7fff, 16'h2000);
      send_command(16'sh8000, 16'sh8000, 16'h8000);
   endtask

   // one command per sector and one near each sector boundary
   task automatic test_sectors();
      for (int s = 0; s < 12; s++)
         send_command(16'sh4000, 16'sh0000, 16'(s * 5461));
      send_command(16'sh0000, 16'sh0000, 16'h1555);
   endtask

   task automatic test_random(int count);
      field_type dv, qv;
      for (int i = 0; i < count; i++) begin
         no_idle = (i >= 300 && i < 450);
         if ($urandom_range(3) == 0) begin
            dv = field_type'($urandom());
            qv = field_type'($urandom());
         end else begin
            // mostly realistic commands inside the linear range
            dv = field_type'($signed($urandom_range(36000)) - 18000);
            qv = field_type'($signed($urandom_range(36000)) - 18000);
         end
         send_command(dv, qv, 16'($urandom()));
      end
      no_idle = 1'b0;
   endtask

   initial begin
      sine_q15_table = build_sine_rom();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_sectors();
      test_random(1030);
      req_bus.valid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d rotor-frame commands, checked %0d duty triples", sent, checked);
      $display("covering rail values, sector boundaries and overmodulation");
      if (errors == 0 && pending_duties.size() == 0) begin
         $display("tb_inverse_park_space_vector_pwm_core: PASS");
      end else begin
         $display("tb_inverse_park_space_vector_pwm_core: FAIL");
      end
      $finish;
   end
endmodule
